FILE: rtl/core/yp2r_pkg.sv
// ----------------------------------------------------------------------------
// yp2r_pkg: shared types and constants for the YUV pair to RGB converter
// BT.601 coefficients in signed 12.16 fixed point, stage enables and the clamp.
// ----------------------------------------------------------------------------
package yp2r_pkg;

  localparam int PAIR_W  = 16;
  localparam int PIXEL_W = 24;
  localparam int BYTE_W  = 8;
  localparam int OFS_W   = 9;   // offset components: -128..239
  localparam int SUM_W   = 28;  // widest channel sum stays below 2^26 in magnitude
  localparam int FRAC_W  = 16;  // signed 12.16 fixed point

  localparam logic signed [SUM_W-1:0] COEF_Y  = SUM_W'(76284);
  localparam logic signed [SUM_W-1:0] COEF_RV = SUM_W'(104595);
  localparam logic signed [SUM_W-1:0] COEF_GU = SUM_W'(25624);   // subtracted
  localparam logic signed [SUM_W-1:0] COEF_GV = SUM_W'(53281);   // subtracted
  localparam logic signed [SUM_W-1:0] COEF_BU = SUM_W'(132251);

  localparam logic [OFS_W-1:0] Y_OFFSET = OFS_W'(16);
  localparam logic [OFS_W-1:0] C_OFFSET = OFS_W'(128);
  localparam logic [BYTE_W-1:0] CHAN_MAX = 8'hff;
  localparam logic [BYTE_W-1:0] CHAN_MIN = 8'h00;

  typedef struct packed {
    logic s1;  // offset stage loads
    logic s2;  // product stage loads
    logic s3;  // sum stage loads
  } stage_en_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] g;
    logic signed [SUM_W-1:0] b;
  } chan_sum_t;

  // Divide by 2^16 truncating toward zero, then clamp to 0..255. A negative
  // sum gives a quotient of zero or below, which clamps to zero either way.
  function automatic logic [BYTE_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [BYTE_W-1:0] q;
    if (s[SUM_W-1]) begin
      q = CHAN_MIN;
    end else if (|s[SUM_W-2:FRAC_W+BYTE_W]) begin
      q = CHAN_MAX;
    end else begin
      q = s[FRAC_W+BYTE_W-1:FRAC_W];
    end
    return q;
  endfunction

endpackage

FILE: rtl/core/yp2r_if.sv
// ----------------------------------------------------------------------------
// yp2r_if: valid/ready channels of the YUV pair to RGB converter
// One interface for the packed YUV word triple, one for the RGB pixel pair.
// ----------------------------------------------------------------------------
interface yp2r_in_if;
  import yp2r_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAIR_W-1:0] luma_pair;
  logic [PAIR_W-1:0] blue_diff_pair;
  logic [PAIR_W-1:0] red_diff_pair;

  modport source (output valid, luma_pair, blue_diff_pair, red_diff_pair, input ready);
  modport sink   (input valid, luma_pair, blue_diff_pair, red_diff_pair, output ready);
endinterface

interface yp2r_out_if;
  import yp2r_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_even;
  logic [PIXEL_W-1:0] pixel_odd;

  modport source (output valid, pixel_even, pixel_odd, input ready);
  modport sink   (input valid, pixel_even, pixel_odd, output ready);
endinterface

FILE: rtl/core/yp2r_pixel_pipe.sv
// ----------------------------------------------------------------------------
// yp2r_pixel_pipe: three-stage datapath for one pixel
// Offsets, coefficient products, channel sums; each stage loads on its enable.
// ----------------------------------------------------------------------------
module yp2r_pixel_pipe (
  input  logic                                 clk,
  input  yp2r_pkg::stage_en_t                  en,
  input  logic [yp2r_pkg::BYTE_W-1:0]          y,
  input  logic [yp2r_pkg::BYTE_W-1:0]          u,
  input  logic [yp2r_pkg::BYTE_W-1:0]          v,
  output yp2r_pkg::chan_sum_t                  sums
);
  import yp2r_pkg::*;

  logic signed [OFS_W-1:0] yo, uo, vo;
  logic signed [SUM_W-1:0] py, prv, pgu, pgv, pbu;
  chan_sum_t               sum_reg;

  // stage 1: remove offsets
  always_ff @(posedge clk) begin
    if (en.s1) begin
      yo <= $signed({1'b0, y} - Y_OFFSET);
      uo <= $signed({1'b0, u} - C_OFFSET);
      vo <= $signed({1'b0, v} - C_OFFSET);
    end
  end

  // stage 2: one multiplier per coefficient
  always_ff @(posedge clk) begin
    if (en.s2) begin
      py  <= SUM_W'(yo) * COEF_Y;
      prv <= SUM_W'(vo) * COEF_RV;
      pgu <= SUM_W'(uo) * COEF_GU;
      pgv <= SUM_W'(vo) * COEF_GV;
      pbu <= SUM_W'(uo) * COEF_BU;
    end
  end

  // stage 3: channel sums
  always_ff @(posedge clk) begin
    if (en.s3) begin
      sum_reg.r <= py + prv;
      sum_reg.g <= py - pgu - pgv;
      sum_reg.b <= py + pbu;
    end
  end

  assign sums = sum_reg;

endmodule

FILE: rtl/core/yuv_pair_to_rgb_pixels.sv
// ----------------------------------------------------------------------------
// yuv_pair_to_rgb_pixels: BT.601 YUV pair to packed RGB pixel pair
// Converts two pixels per word in a four-stage pipeline with collapsing bubbles.
// ----------------------------------------------------------------------------
//
//   channel    dir  handshake     payload
//   pair_in    in   valid/ready   luma_pair, blue_diff_pair, red_diff_pair (16b each)
//   pixel_out  out  valid/ready   pixel_even, pixel_odd (24b each, R 7:0 G 15:8 B 23:16)
//
// One word per cycle sustained while pixel_out is not stalled; an accepted
// word passes the offset, product, sum and clamp/output registers in order.
// Reset clears only the stage valid bits; the datapath carries no reset.
// A stage loads whenever it is empty or the stage after it advances, so
// bubbles collapse under a stall and pair_in.ready drops only when all four
// stages hold words and pixel_out is stalled.
//
module yuv_pair_to_rgb_pixels (
  input logic         clk,
  input logic         rst,
  yp2r_in_if.sink     pair_in,
  yp2r_out_if.source  pixel_out
);
  import yp2r_pkg::*;

  stage_en_t          en;
  logic               v1, v2, v3, ov;
  logic               out_free;
  chan_sum_t          sum_even, sum_odd;
  logic [PIXEL_W-1:0] pix_even, pix_odd;

  // Backward enables: a stage advances when it is empty or its successor takes it.
  assign out_free = !ov || pixel_out.ready;
  assign en.s3    = !v3 || out_free;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;

  assign pair_in.ready = en.s1;

  // Valid bits travel with the data; hold them when the stage is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en.s1) v1 <= pair_in.valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (out_free) ov <= v3;
    end
  end

  // Even pixel in the low bytes, odd pixel in the high bytes.
  yp2r_pixel_pipe u_even (
    .clk  (clk),
    .en   (en),
    .y    (pair_in.luma_pair[BYTE_W-1:0]),
    .u    (pair_in.blue_diff_pair[BYTE_W-1:0]),
    .v    (pair_in.red_diff_pair[BYTE_W-1:0]),
    .sums (sum_even)
  );

  yp2r_pixel_pipe u_odd (
    .clk  (clk),
    .en   (en),
    .y    (pair_in.luma_pair[PAIR_W-1:BYTE_W]),
    .u    (pair_in.blue_diff_pair[PAIR_W-1:BYTE_W]),
    .v    (pair_in.red_diff_pair[PAIR_W-1:BYTE_W]),
    .sums (sum_odd)
  );

  // Output register: scale, clamp and pack; hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (out_free) begin
      pix_even <= {clamp_chan(sum_even.b), clamp_chan(sum_even.g), clamp_chan(sum_even.r)};
      pix_odd  <= {clamp_chan(sum_odd.b), clamp_chan(sum_odd.g), clamp_chan(sum_odd.r)};
    end
  end

  assign pixel_out.valid      = ov;
  assign pixel_out.pixel_even = pix_even;
  assign pixel_out.pixel_odd  = pix_odd;

`ifndef SYNTHESIS
  // Back-pressure reaches the input only with every stage full and the sink stalled.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !pair_in.ready |-> (v1 && v2 && v3 && ov && !pixel_out.ready))
    else $error("input stalled while a pipeline stage is free");

  // An accepted word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pair_in.valid && pair_in.ready) |=> v1)
    else $error("accepted word lost at stage one");

  // A finished sum moves into an empty output register at once.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ov) |=> ov)
    else $error("output register failed to take a finished word");

  // A stalled output word keeps stage three's word in place.
  a_hold3: assert property (@(posedge clk) disable iff (rst)
    (v3 && ov && !pixel_out.ready) |=> v3)
    else $error("stage three dropped a word under a stall");
`endif

endmodule
